### rtl/lnser_pkg.sv
// Shared types and constants for the natural log series partial sum block.
package lnser_pkg;

  localparam int unsigned FracR       = 62;
  localparam int unsigned ResShift    = 14;
  localparam int unsigned MaxTermsDef = 16777216;
  localparam logic [63:0] OneQ62      = 64'h4000_0000_0000_0000;
  localparam logic [52:0] ResMax      = {53{1'b1}};
  localparam logic [6:0]  RStepsFrac  = 7'd62;
  localparam logic [6:0]  RStepsTerm  = 7'd48;

  // Sequencer states, one-hot.
  typedef enum logic [9:0] {
    ST_IDLE = 10'b00_0000_0001,
    ST_DIVR = 10'b00_0000_0010,
    ST_SQR  = 10'b00_0000_0100,
    ST_EXPA = 10'b00_0000_1000,
    ST_EXPB = 10'b00_0001_0000,
    ST_POT  = 10'b00_0010_0000,
    ST_TCHK = 10'b00_0100_0000,
    ST_TDIV = 10'b00_1000_0000,
    ST_TMUL = 10'b01_0000_0000,
    ST_OUT  = 10'b10_0000_0000
  } lnser_state_e;

  // Request to the shared divider.
  typedef struct packed {
    logic        start;
    logic [32:0] den;
    logic [32:0] rem0;
    logic [63:0] dividend;
    logic [6:0]  steps;
  } lnser_div_req_t;

endpackage

### rtl/natural_log_series_partial_sum.sv
// Top level: sequencer for the atanh series partial sum of ln(x).
//
//  channel  | dir | tdata fields (low bit up)                   | tuser/tlast
//  s_axis   | in  | x_value[31:0] first_term[55:32] last_term[79:56] | none
//  m_axis   | out | ln_partial[52:0], zero pad [55:53]          | none
//
// One request runs the 62-step fraction divide, the squaring and the power by square
// and multiply, then per term the 48-step divider plus one multiply. An empty range
// or zero x goes straight to the output.
// Reset clears the sequencer and the unit control only. s_axis_tready is high only while idle;
// a result is held on m_axis until it is taken.
module natural_log_series_partial_sum #(
  parameter int unsigned MAX_TERMS = lnser_pkg::MaxTermsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,   // x_value, first_term, last_term
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata    // ln_partial, zero pad
);
  import lnser_pkg::*;

  localparam logic [24:0] LastMax = 25'(MAX_TERMS - 1);

  lnser_state_e   state_q, state_d;
  logic [31:0]    x_q;
  logic [23:0]    first_q, last_q, e_q;
  logic [63:0]    r_q, r2_q, acc_q, base_q, pot_q, sum_q;
  logic [24:0]    n_q;
  logic [52:0]    res_q;
  logic           mul_go_q, div_go_q;
  logic [63:0]    mul_a, mul_b, mul_p, quot;
  logic           mul_done, div_done;
  lnser_div_req_t div_req;
  logic [31:0]    in_x;
  logic [23:0]    in_first, in_last, in_last_c, e_nx;
  logic           accept;

  assign in_x      = s_axis_tdata[31:0];
  assign in_first  = s_axis_tdata[55:32];
  assign in_last   = s_axis_tdata[79:56];
  assign in_last_c = ({1'b0, in_last} > LastMax) ? LastMax[23:0] : in_last;
  assign accept    = s_axis_tvalid && s_axis_tready;
  assign e_nx      = {1'b0, e_q[23:1]};

  // Operand selection for the shared multiplier.
  always_comb begin
    case (state_q)
      ST_SQR:  begin mul_a = r_q;   mul_b = r_q;    end
      ST_EXPA: begin mul_a = acc_q; mul_b = base_q; end
      ST_EXPB: begin mul_a = base_q; mul_b = base_q; end
      ST_POT:  begin mul_a = acc_q; mul_b = r_q;    end
      ST_TMUL: begin mul_a = pot_q; mul_b = r2_q;   end
      default: begin mul_a = 64'd0; mul_b = 64'd0;  end
    endcase
  end

  // Request to the shared divider: the fraction r or one series term.
  always_comb begin
    div_req.start = div_go_q;
    if (state_q == ST_DIVR) begin
      div_req.den      = {1'b0, x_q} + 33'd1;
      div_req.rem0     = {1'b0, x_q} - 33'd1;
      div_req.dividend = 64'd0;
      div_req.steps    = RStepsFrac;
    end else begin
      div_req.den      = {7'd0, n_q, 1'b1};
      div_req.rem0     = 33'd0;
      div_req.dividend = {pot_q[61:ResShift], 16'd0};
      div_req.steps    = RStepsTerm;
    end
  end

  lnser_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_go_q),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  lnser_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (quot)
  );

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      mul_go_q <= 1'b0;
      div_go_q <= 1'b0;
    end else begin
      mul_go_q <= 1'b0;
      div_go_q <= 1'b0;
      state_q  <= state_d;
      case (state_q)
        ST_IDLE: if (accept && state_d == ST_DIVR) div_go_q <= 1'b1;
        ST_DIVR: if (div_done) mul_go_q <= 1'b1;
        ST_SQR, ST_EXPA, ST_EXPB, ST_TDIV: if (mul_done || div_done) mul_go_q <= 1'b1;
        ST_TCHK: if (state_d == ST_TDIV) div_go_q <= 1'b1;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept) begin
        state_d = (in_x == 32'd0 || in_first > in_last_c) ? ST_OUT : ST_DIVR;
      end
      ST_DIVR: if (div_done) state_d = ST_SQR;
      ST_SQR: if (mul_done) begin
        if (first_q == 24'd0)  state_d = ST_POT;
        else if (first_q[0])   state_d = ST_EXPA;
        else                   state_d = ST_EXPB;
      end
      ST_EXPA: if (mul_done) state_d = ST_EXPB;
      ST_EXPB: if (mul_done) begin
        if (e_nx == 24'd0) state_d = ST_POT;
        else if (e_nx[0])  state_d = ST_EXPA;
        else               state_d = ST_EXPB;
      end
      ST_POT:  if (mul_done) state_d = ST_TCHK;
      ST_TCHK: state_d = (n_q > {1'b0, last_q} || pot_q == 64'd0) ? ST_OUT : ST_TDIV;
      ST_TDIV: if (div_done) state_d = ST_TMUL;
      ST_TMUL: if (mul_done) state_d = ST_TCHK;
      ST_OUT:  if (m_axis_tready) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: if (accept) begin
        x_q     <= in_x;
        first_q <= in_first;
        last_q  <= in_last_c;
        res_q   <= 53'd0;
      end
      ST_DIVR: if (div_done) r_q <= quot;
      ST_SQR: if (mul_done) begin
        r2_q   <= mul_p;
        base_q <= mul_p;
        acc_q  <= OneQ62;
        e_q    <= first_q;
      end
      ST_EXPA: if (mul_done) acc_q <= mul_p;
      ST_EXPB: if (mul_done) begin
        base_q <= mul_p;
        e_q    <= e_nx;
      end
      ST_POT: if (mul_done) begin
        pot_q <= mul_p;
        n_q   <= {1'b0, first_q};
        sum_q <= 64'd0;
      end
      ST_TCHK: begin
        if (sum_q > {12'd0, ResMax[52:1]}) res_q <= ResMax;
        else                                res_q <= {sum_q[51:0], 1'b0};
      end
      ST_TDIV: if (div_done) sum_q <= sum_q + quot;
      ST_TMUL: if (mul_done) begin
        pot_q <= mul_p;
        n_q   <= n_q + 25'd1;
      end
      default: ;
    endcase
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = (state_q == ST_OUT);
  assign m_axis_tdata  = {3'd0, res_q};

  // The two shared units never finish in the same cycle.
  a_units_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mul_done && div_done)) else $error("multiplier and divider both done");

  // No new request is taken while a result waits.
  a_in_out_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("ready while result pending");

  // After a request is taken the block is busy in the next cycle.
  a_busy_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !s_axis_tready) else $error("ready right after accept");

  // A result leaves only after the term loop or an empty request.
  a_out_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> ($past(state_q) == ST_TCHK || $past(state_q) == ST_IDLE))
    else $error("result shown from wrong state");

endmodule

### rtl/lnser_mul.sv
// Iterative Q2.62 multiplier built from four 32x32 partial products.
module lnser_mul (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic        done_o,
  output logic [63:0] p_o
);
  import lnser_pkg::*;

  logic [63:0]  a_q, b_q;
  logic [127:0] prod_q;
  logic [1:0]   cnt_q;
  logic         run_q, done_q;
  logic [31:0]  op_a, op_b;
  logic [63:0]  part;
  logic [127:0] part_sh;

  // Select the partial product for this cycle and align it.
  always_comb begin
    op_a = cnt_q[1] ? a_q[63:32] : a_q[31:0];
    op_b = cnt_q[0] ? b_q[63:32] : b_q[31:0];
    part = op_a * op_b;
    case ({1'b0, cnt_q[1]} + {1'b0, cnt_q[0]})
      2'd0:    part_sh = {64'd0, part};
      2'd1:    part_sh = {32'd0, part, 32'd0};
      2'd2:    part_sh = {part, 64'd0};
      default: part_sh = 128'd0;
    endcase
  end

  // Control of the accumulation of the four partial products.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= 2'd0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Operands and product accumulator.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q    <= a_i;
      b_q    <= b_i;
      prod_q <= 128'd0;
    end else if (run_q) begin
      prod_q <= prod_q + part_sh;
    end
  end

  assign done_o = done_q;
  assign p_o    = prod_q[FracR+63:FracR];

endmodule

### rtl/lnser_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module lnser_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  lnser_pkg::lnser_div_req_t req_i,
  output logic                      done_o,
  output logic [63:0]               quot_o
);
  import lnser_pkg::*;

  logic [32:0] den_q, rem_q;
  logic [63:0] dvd_q, quot_q;
  logic [6:0]  cnt_q;
  logic        run_q, done_q;
  logic [33:0] rem_sh;
  logic        fits;

  // One restoring step: shift in the next dividend bit and try a subtract.
  always_comb begin
    rem_sh = {rem_q, dvd_q[63]};
    fits   = rem_sh >= {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 7'd0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        run_q <= 1'b1;
        cnt_q <= req_i.steps;
      end else if (run_q) begin
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      den_q  <= req_i.den;
      rem_q  <= req_i.rem0;
      dvd_q  <= req_i.dividend;
      quot_q <= 64'd0;
    end else if (run_q) begin
      dvd_q  <= {dvd_q[62:0], 1'b0};
      quot_q <= {quot_q[62:0], fits};
      rem_q  <= fits ? 33'(rem_sh - {1'b0, den_q}) : rem_sh[32:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

### tb/sv/testbench.sv
// Testbench for the natural log series partial sum block: directed and random requests.
`timescale 1ns / 1ps

module testbench;

  import lnser_pkg::*;

  localparam int unsigned TermCap   = 24'hFF_FFFF;
  localparam int unsigned HoldCycles = 3000;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [55:0] m_axis_tdata;

  logic [52:0] ln_expected_q[$];
  int unsigned n_sent;
  int unsigned n_checked;
  int unsigned n_errors;
  int unsigned n_empty;
  logic        hold_req;
  logic        hold_ack;
  int unsigned hold_cnt;
  int unsigned ready_mode_cnt;
  logic        ready_steady;

  natural_log_series_partial_sum i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Clock with a 20 ns period.
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Unsigned Q2.62 product, truncated.
  function automatic logic [63:0] q62_mul(logic [63:0] a, logic [63:0] b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return prod[125:62];
  endfunction

  // Expected twice-partial-sum of the atanh series for one request.
  function automatic logic [52:0] ln_partial_sum(logic [31:0] x, logic [23:0] first,
                                                 logic [23:0] last);
    logic [95:0]       quot;
    logic [63:0]       r;
    logic [63:0]       r2;
    logic [63:0]       acc;
    logic [63:0]       base;
    logic [63:0]       pot;
    logic [63:0]       sum;
    logic [23:0]       e;
    longint unsigned   n;
    if (x == 32'd0 || first > last) return '0;
    quot = ({64'd0, x - 32'd1} << 62) / {63'd0, {1'b0, x} + 33'd1};
    r    = quot[63:0];
    r2   = q62_mul(r, r);
    // Starting power r^(2*first+1) by square and multiply.
    acc  = OneQ62;
    base = r2;
    for (e = first; e != 0; e = e >> 1) begin
      if (e[0]) acc = q62_mul(acc, base);
      base = q62_mul(base, base);
    end
    pot = q62_mul(acc, r);
    sum = '0;
    for (n = first; n <= last; n++) begin
      if (pot == 0) break;
      sum += (pot >> ResShift) / (2 * n + 1);
      pot = q62_mul(pot, r2);
    end
    if (sum > ({11'd0, ResMax} >> 1)) return ResMax;
    return {sum[51:0], 1'b0};
  endfunction

  // Offers one request and waits until the block takes it.
  task automatic send_request(logic [31:0] x, logic [23:0] first, logic [23:0] last);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {last, first, x};
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
    ln_expected_q = {ln_expected_q, ln_partial_sum(x, first, last)};
    n_sent++;
    if (first > last) n_empty++;
  endtask

  // Drops valid for a random number of cycles, or none at all.
  task automatic sender_gap(int unsigned max_gap);
    int unsigned gap;
    gap = $urandom_range(0, max_gap);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (ln_expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Field extremes and the argument range.
  task automatic test_extremes();
    send_request(32'd1, 24'd0, 24'd0);
    send_request(32'd2, 24'd0, 24'd9);
    send_request(32'd3, 24'd0, 24'd15);
    send_request(32'hFFFF_FFFF, 24'd0, 24'd63);
    send_request(32'hFFFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF);
    sender_gap(3);
    send_request(32'h8000_0000, 24'hAA_AAAA, 24'hAA_AAB0);
    send_request(32'h5555_5555, 24'h55_5555, 24'h55_5560);
    send_request(32'd10, 24'd0, 24'd40);
    send_request(32'd1000, 24'd1, 24'd1);
    wait_idle();
  endtask

  // Empty range, zero argument, term clamp and vanished power.
  task automatic test_special_cases();
    send_request(32'd50, 24'd5, 24'd4);
    send_request(32'd50, 24'hFF_FFFF, 24'd0);
    send_request(32'd0, 24'd0, 24'd20);
    send_request(32'd0, 24'hFF_FFFF, 24'hFF_FFFF);
    send_request(32'd7, 24'hFF_FFF0, 24'hFF_FFFF);
    send_request(32'd1, 24'd0, 24'hFF_FFFF);
    send_request(32'd2, 24'd0, 24'hFF_FFFF);
    send_request(32'd3, 24'd3, 24'hFF_FFFF);
    send_request(32'd2, 24'h00_1000, 24'h00_1010);
    wait_idle();
  endtask

  // Random requests in bursts; ranges kept short unless the power vanishes fast.
  task automatic test_random(int unsigned count);
    logic [31:0] x;
    logic [23:0] first;
    logic [23:0] last;
    int unsigned burst;
    int unsigned span;
    burst = 0;
    for (int unsigned i = 0; i < count; i++) begin
      case ($urandom_range(0, 3))
        0:       x = $urandom_range(0, 16);
        1:       x = 32'd1 << $urandom_range(0, 31);
        default: x = $urandom;
      endcase
      first = ($urandom_range(0, 2) == 0) ? 24'($urandom) : 24'($urandom_range(0, 40));
      span  = $urandom_range(0, 40);
      case ($urandom_range(0, 7))
        0:       last = 24'($urandom);
        1:       last = (first == 0) ? 24'd0 : first - 24'($urandom_range(1, 3));
        default: last = ({8'd0, first} + span > TermCap) ? 24'(TermCap) : first + 24'(span);
      endcase
      // Long ranges only where r is small enough for the power to die out.
      if (last > first && last - first > 64 && x > 32'd3) last = first + 24'(span);
      send_request(x, first, last);
      if (burst == 0) begin
        burst = $urandom_range(1, 8);
        sender_gap(30);
      end else begin
        burst--;
      end
    end
    wait_idle();
  endtask

  // Long receiver hold while the sender keeps offering requests.
  task automatic test_backpressure();
    hold_req <= ~hold_req;
    for (int unsigned i = 0; i < 6; i++)
      send_request($urandom, 24'($urandom_range(0, 8)), 24'($urandom_range(0, 12)));
    wait_idle();
  endtask

  // Receiver: random stalls, stall-free stretches, and the long hold.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready  <= 1'b0;
      hold_ack       <= 1'b0;
      hold_cnt       <= 0;
      ready_mode_cnt <= 0;
      ready_steady   <= 1'b0;
    end else begin
      if (ready_mode_cnt == 0) begin
        ready_mode_cnt <= $urandom_range(50, 400);
        ready_steady   <= ($urandom_range(0, 2) == 0);
      end else begin
        ready_mode_cnt <= ready_mode_cnt - 1;
      end
      if (hold_req != hold_ack) begin
        hold_ack      <= hold_req;
        hold_cnt      <= HoldCycles;
        m_axis_tready <= 1'b0;
      end else if (hold_cnt != 0) begin
        hold_cnt      <= hold_cnt - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ready_steady || ($urandom_range(0, 3) != 0);
      end
    end
  end

  // Result checker, sampled mid-cycle when handshake signals are settled.
  always @(negedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (ln_expected_q.size() == 0) begin
        $display("%0t: unexpected result ln_partial=%h", $time, m_axis_tdata[52:0]);
        n_errors++;
      end else begin
        if (m_axis_tdata[52:0] !== ln_expected_q[0]) begin
          $display("%0t: ln_partial mismatch: expected %h, actual %h", $time,
                   ln_expected_q[0], m_axis_tdata[52:0]);
          n_errors++;
        end
        void'(ln_expected_q.pop_front());
        n_checked++;
      end
    end
  end

  initial begin
    n_sent        = 0;
    n_checked     = 0;
    n_errors      = 0;
    n_empty       = 0;
    hold_req      = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_special_cases();
    test_backpressure();
    test_random(76);
    if (ln_expected_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, ln_expected_q.size());
      n_errors++;
    end
    $display("Covered %0d requests (%0d empty ranges), %0d results checked, %0d errors.",
             n_sent, n_empty, n_checked, n_errors);
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #60ms;
    $display("%0t: timeout with %0d results outstanding", $time, ln_expected_q.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

### sim.f
rtl/lnser_pkg.sv
rtl/lnser_mul.sv
rtl/lnser_div.sv
rtl/natural_log_series_partial_sum.sv
tb/sv/testbench.sv
